[rtl/core/maze_wall_follower_walker_macros.svh]
// Assertion macros shared by the checker of the maze walker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef MAZE_WALL_FOLLOWER_WALKER_MACROS_SVH
`define MAZE_WALL_FOLLOWER_WALKER_MACROS_SVH

// A property that must hold at every clock edge.
`define MWFW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that forces a consequence in the next cycle.
`define MWFW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

[rtl/core/mwfw_pkg.sv]
// Package of the maze walker: cell and direction codes, item kinds,
// controller states and the command and status structs. No dependencies.
package mwfw_pkg;

  localparam int GRID_ROWS_DEF = 32;
  localparam int GRID_COLS_DEF = 32;

  localparam logic [1:0] CELL_OPEN    = 2'd0;
  localparam logic [1:0] CELL_WALL    = 2'd1;
  localparam logic [1:0] CELL_FINISH  = 2'd2;
  localparam logic [1:0] CELL_VISITED = 2'd3;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_STEP  = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DIR_EAST  = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_WEST  = 2'd2,
    DIR_NORTH = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    TURN_AHEAD = 2'd0,
    TURN_RIGHT = 2'd1,
    TURN_BACK  = 2'd2,
    TURN_LEFT  = 2'd3
  } turn_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_AHEAD,
    ST_RIGHT,
    ST_LEFT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic  latch;
    logic  clr_wr;
    logic  cell_wr;
    logic  start_set;
    logic  rd_item;
    logic  rd_nbr;
    logic  move;
    logic  turn;
    logic  set_fin;
    logic  save_ahead;
    logic  out_load;
    turn_t rel;
  } cmd_t;

  typedef struct packed {
    kind_t      kind;
    logic       finished;
    logic       clr_last;
    logic [1:0] rd_code;
    logic [1:0] ahead_code;
  } sts_t;

endpackage

[rtl/core/mwfw_ctrl.sv]
// Controller of the maze walker: sequences the clearing pass, item dispatch
// and the steps of one walk. Depends on mwfw_pkg.
module mwfw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mwfw_pkg::sts_t sts,
  output mwfw_pkg::cmd_t cmd
);
  import mwfw_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = ST_RESULT;
        case (sts.kind)
          KIND_WRITE: cmd.cell_wr = 1'b1;
          KIND_START: cmd.start_set = 1'b1;
          KIND_READ:  cmd.rd_item = 1'b1;
          KIND_STEP: begin
            if (!sts.finished) begin
              cmd.rd_nbr = 1'b1;
              cmd.rel    = TURN_AHEAD;
              state_nxt  = ST_AHEAD;
            end
          end
          default: state_nxt = ST_RESULT;
        endcase
      end
      ST_AHEAD: begin
        if (sts.rd_code == CELL_FINISH) begin
          cmd.set_fin = 1'b1;
          state_nxt   = ST_RESULT;
        end else begin
          cmd.save_ahead = 1'b1;
          cmd.rd_nbr     = 1'b1;
          cmd.rel        = TURN_RIGHT;
          state_nxt      = ST_RIGHT;
        end
      end
      ST_RIGHT: begin
        if (sts.rd_code != CELL_WALL) begin
          cmd.move  = 1'b1;
          cmd.turn  = 1'b1;
          cmd.rel   = TURN_RIGHT;
          state_nxt = ST_RESULT;
        end else if (sts.ahead_code != CELL_WALL) begin
          cmd.move  = 1'b1;
          cmd.rel   = TURN_AHEAD;
          state_nxt = ST_RESULT;
        end else begin
          cmd.rd_nbr = 1'b1;
          cmd.rel    = TURN_LEFT;
          state_nxt  = ST_LEFT;
        end
      end
      ST_LEFT: begin
        cmd.turn  = 1'b1;
        cmd.rel   = (sts.rd_code != CELL_WALL) ? TURN_LEFT : TURN_BACK;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/mwfw_dpath.sv]
// Datapath of the maze walker: grid memory, walker position and heading,
// neighbor addressing and the result register. Depends on mwfw_pkg.
module mwfw_dpath #(
  parameter int GRID_ROWS = mwfw_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = mwfw_pkg::GRID_COLS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mwfw_pkg::cmd_t cmd,
  output mwfw_pkg::sts_t sts,
  input  logic [1:0]     in_kind,
  input  logic [4:0]     in_row,
  input  logic [4:0]     in_col,
  input  logic [1:0]     in_cell_code,
  output logic [4:0]     out_pos_row,
  output logic [4:0]     out_pos_col,
  output logic [1:0]     out_heading,
  output logic           out_moved,
  output logic           out_done_res,
  output logic [1:0]     out_read_code
);
  import mwfw_pkg::*;

  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [RW-1:0] LAST_ROW = RW'(GRID_ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(GRID_COLS - 1);

  logic [1:0] mem [DEPTH];

  kind_t         kind_r, kind_nxt;
  logic [4:0]    row_r, row_nxt;
  logic [4:0]    col_r, col_nxt;
  logic [1:0]    code_r, code_nxt;
  logic [RW-1:0] walker_row_r, walker_row_nxt;
  logic [CW-1:0] walker_col_r, walker_col_nxt;
  dir_t          heading_r, heading_nxt;
  logic          finished_r, finished_nxt;
  logic          moved_r, moved_nxt;
  logic [1:0]    ahead_r, ahead_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [1:0]    rd_data_r;
  logic          rd_oob_r;

  logic [4:0]    out_pos_row_r, out_pos_col_r;
  logic [1:0]    out_heading_r, out_read_code_r;
  logic          out_moved_r, out_done_res_r;

  logic [RW+4:0] item_row_ext;
  logic [CW+4:0] item_col_ext;
  logic [RW+4:0] walker_row_ext;
  logic [CW+4:0] walker_col_ext;
  logic [RW-1:0] item_row;
  logic [CW-1:0] item_col;
  logic          in_grid;
  dir_t          dir;
  logic [RW-1:0] nbr_row;
  logic [CW-1:0] nbr_col;
  logic          nbr_oob;
  logic [1:0]    rd_code;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;

  always_comb begin
    item_row_ext   = {{RW{1'b0}}, row_r};
    item_col_ext   = {{CW{1'b0}}, col_r};
    walker_row_ext = {5'b0, walker_row_r};
    walker_col_ext = {5'b0, walker_col_r};
    item_row       = item_row_ext[RW-1:0];
    item_col       = item_col_ext[CW-1:0];
    in_grid        = (32'(row_r) < GRID_ROWS) && (32'(col_r) < GRID_COLS);
    rd_code        = rd_oob_r ? CELL_WALL : rd_data_r;
    dir            = dir_t'(2'(heading_r + cmd.rel));

    nbr_row = walker_row_r;
    nbr_col = walker_col_r;
    nbr_oob = 1'b0;
    case (dir)
      DIR_EAST: begin
        if (walker_col_r == LAST_COL) nbr_oob = 1'b1;
        else nbr_col = walker_col_r + 1'b1;
      end
      DIR_SOUTH: begin
        if (walker_row_r == LAST_ROW) nbr_oob = 1'b1;
        else nbr_row = walker_row_r + 1'b1;
      end
      DIR_WEST: begin
        if (walker_col_r == '0) nbr_oob = 1'b1;
        else nbr_col = walker_col_r - 1'b1;
      end
      DIR_NORTH: begin
        if (walker_row_r == '0) nbr_oob = 1'b1;
        else nbr_row = walker_row_r - 1'b1;
      end
      default: nbr_oob = 1'b1;
    endcase

    mem_we    = cmd.clr_wr || (cmd.cell_wr && in_grid) || cmd.move;
    mem_waddr = {item_row, item_col};
    mem_wdata = code_r;
    if (cmd.clr_wr) begin
      mem_waddr = clr_cnt_r;
      mem_wdata = CELL_OPEN;
    end else if (cmd.move) begin
      mem_waddr = {walker_row_r, walker_col_r};
      mem_wdata = CELL_VISITED;
    end
    mem_raddr = cmd.rd_item ? {item_row, item_col} : {nbr_row, nbr_col};
  end

  always_comb begin
    kind_nxt       = kind_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    code_nxt       = code_r;
    walker_row_nxt = walker_row_r;
    walker_col_nxt = walker_col_r;
    heading_nxt    = heading_r;
    finished_nxt   = finished_r;
    moved_nxt      = moved_r;
    ahead_nxt      = ahead_r;
    clr_cnt_nxt    = clr_cnt_r;
    if (cmd.latch) begin
      kind_nxt  = kind_t'(in_kind);
      row_nxt   = in_row;
      col_nxt   = in_col;
      code_nxt  = in_cell_code;
      moved_nxt = 1'b0;
    end
    if (cmd.clr_wr) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end
    if (cmd.start_set && in_grid) begin
      walker_row_nxt = item_row;
      walker_col_nxt = item_col;
      heading_nxt    = DIR_EAST;
      finished_nxt   = 1'b0;
    end
    if (cmd.move) begin
      walker_row_nxt = nbr_row;
      walker_col_nxt = nbr_col;
      moved_nxt      = 1'b1;
      if (rd_code == CELL_FINISH) finished_nxt = 1'b1;
    end
    if (cmd.turn) begin
      heading_nxt = dir;
    end
    if (cmd.set_fin) begin
      finished_nxt = 1'b1;
    end
    if (cmd.save_ahead) begin
      ahead_nxt = rd_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walker_row_r <= '0;
      walker_col_r <= '0;
      heading_r    <= DIR_EAST;
      finished_r   <= 1'b0;
      clr_cnt_r    <= '0;
    end else begin
      walker_row_r <= walker_row_nxt;
      walker_col_r <= walker_col_nxt;
      heading_r    <= heading_nxt;
      finished_r   <= finished_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    code_r  <= code_nxt;
    moved_r <= moved_nxt;
    ahead_r <= ahead_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_item || cmd.rd_nbr) begin
      rd_data_r <= mem[mem_raddr];
      rd_oob_r  <= cmd.rd_item ? !in_grid : nbr_oob;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pos_row_r   <= walker_row_ext[4:0];
      out_pos_col_r   <= walker_col_ext[4:0];
      out_heading_r   <= heading_r;
      out_moved_r     <= moved_r;
      out_done_res_r  <= finished_r;
      out_read_code_r <= (kind_r == KIND_READ) ? rd_code : CELL_OPEN;
    end
  end

  always_comb begin
    sts.kind       = kind_r;
    sts.finished   = finished_r;
    sts.clr_last   = (clr_cnt_r == '1);
    sts.rd_code    = rd_code;
    sts.ahead_code = ahead_r;
  end

  assign out_pos_row   = out_pos_row_r;
  assign out_pos_col   = out_pos_col_r;
  assign out_heading   = out_heading_r;
  assign out_moved     = out_moved_r;
  assign out_done_res  = out_done_res_r;
  assign out_read_code = out_read_code_r;

endmodule

[rtl/core/maze_wall_follower_walker.sv]
// Top level of the right-hand wall-following maze walker.
// Instantiates mwfw_ctrl and mwfw_dpath; depends on mwfw_pkg.
//
// The block works on one item at a time on a single-port grid memory whose
// read data is registered. After reset it clears all 2**(clog2(GRID_ROWS) +
// clog2(GRID_COLS)) grid cells (1024 at the default 32 by 32 grid), one cell
// per cycle, and takes no item until that pass is over. Then a write, start or
// read item passes through the dispatch and result states. A step reads the
// cell ahead, then the cell to the right, then the cell to the left from the
// grid memory, one state for each, and stops reading once the walk is finished,
// the finish lies ahead or the walker can move. A result that is not taken
// holds the block in its result state until it is.
module maze_wall_follower_walker #(
  parameter int GRID_ROWS = mwfw_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = mwfw_pkg::GRID_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [4:0] in_row,
  input  logic [4:0] in_col,
  input  logic [1:0] in_cell_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_pos_row,
  output logic [4:0] out_pos_col,
  output logic [1:0] out_heading,
  output logic       out_moved,
  output logic       out_done_res,
  output logic [1:0] out_read_code
);
  import mwfw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mwfw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mwfw_dpath #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_kind),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_cell_code  (in_cell_code),
    .out_pos_row   (out_pos_row),
    .out_pos_col   (out_pos_col),
    .out_heading   (out_heading),
    .out_moved     (out_moved),
    .out_done_res  (out_done_res),
    .out_read_code (out_read_code)
  );

endmodule

[rtl/core/mwfw_checker.sv]
// Port-level checker of the maze walker, bound to the top level.
// Depends on maze_wall_follower_walker_macros.svh.
`include "maze_wall_follower_walker_macros.svh"

module mwfw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_kind,
  input logic [4:0] in_row,
  input logic [4:0] in_col,
  input logic [1:0] in_cell_code,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_pos_row,
  input logic [4:0] out_pos_col,
  input logic [1:0] out_heading,
  input logic       out_moved,
  input logic       out_done_res,
  input logic [1:0] out_read_code
);

  logic out_stall;
  logic in_take;

  assign out_stall = out_valid && !out_ready;
  assign in_take   = in_valid && in_ready;

  `MWFW_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_pos_row) && $stable(out_pos_col) && $stable(out_heading) && $stable(out_moved) && $stable(out_read_code), "result item changed while stalled")
  `MWFW_ASSERT_ALWAYS(a_moved_no_read, !(out_valid && out_moved && (out_read_code != 2'd0)), "a step item returned a read code")
  `MWFW_ASSERT_NEXT(a_busy_after_take, in_take, !in_ready, "second item taken while one is in work")

endmodule

bind maze_wall_follower_walker mwfw_checker u_chk (.*);
